@@ design/lpb_pkg.sv @@
// Shared types, constants and the microcode program of the biquad cascade.
`default_nettype none
package lpb_pkg;

    localparam int LPB_SAMPLE_WIDTH   = 24;
    localparam int LPB_COEF_FRAC_BITS = 20;
    localparam int COEF_W             = 24;
    localparam int CFG_IDX_W          = 3;
    localparam int STEP_W             = 4;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [COEF_W-1:0]    coef_t;
    typedef logic [STEP_W-1:0]    step_t;

    // Register indexes of the configuration port
    localparam cfg_idx_t REG_LP_GAIN     = 3'd0;
    localparam cfg_idx_t REG_LP_FB_OLDER = 3'd1;
    localparam cfg_idx_t REG_LP_FB_NEWER = 3'd2;
    localparam cfg_idx_t REG_PK_FF_OLDER = 3'd3;
    localparam cfg_idx_t REG_PK_FF_NEWER = 3'd4;
    localparam cfg_idx_t REG_PK_FB_OLDER = 3'd5;
    localparam cfg_idx_t REG_PK_FB_NEWER = 3'd6;
    localparam cfg_idx_t REG_PK_GAIN     = 3'd7;

    localparam coef_t LP_GAIN_RESET = 24'd262144;
    localparam coef_t PK_GAIN_RESET = 24'd1048576;

    // Coefficient operand select
    typedef logic [3:0] coef_sel_t;
    localparam coef_sel_t CS_LP_G     = 4'd0;
    localparam coef_sel_t CS_LP_2G    = 4'd1;
    localparam coef_sel_t CS_LP_FBO   = 4'd2;
    localparam coef_sel_t CS_LP_FBN   = 4'd3;
    localparam coef_sel_t CS_PK_FFO   = 4'd4;
    localparam coef_sel_t CS_PK_FFN   = 4'd5;
    localparam coef_sel_t CS_PK_FBO   = 4'd6;
    localparam coef_sel_t CS_PK_FBN   = 4'd7;
    localparam coef_sel_t CS_PK_G     = 4'd8;

    // Sample operand select
    typedef logic [2:0] smp_sel_t;
    localparam smp_sel_t SS_X   = 3'd0;
    localparam smp_sel_t SS_XN  = 3'd1;
    localparam smp_sel_t SS_XO  = 3'd2;
    localparam smp_sel_t SS_S1N = 3'd3;
    localparam smp_sel_t SS_S1O = 3'd4;
    localparam smp_sel_t SS_S2N = 3'd5;
    localparam smp_sel_t SS_S2O = 3'd6;
    localparam smp_sel_t SS_Y1  = 3'd7;

    // Accumulator operation on the registered product
    typedef logic [1:0] acc_op_t;
    localparam acc_op_t AOP_NONE = 2'd0;
    localparam acc_op_t AOP_LOAD = 2'd1;
    localparam acc_op_t AOP_ADD  = 2'd2;

    // Step action: CHKX ends with zero on zero input, RND1 ends with zero on
    // zero first-stage result, RND2 always ends with the filtered sample.
    typedef logic [1:0] act_t;
    localparam act_t ACT_NONE = 2'd0;
    localparam act_t ACT_CHKX = 2'd1;
    localparam act_t ACT_RND1 = 2'd2;
    localparam act_t ACT_RND2 = 2'd3;

    typedef struct packed {
        coef_sel_t csel;
        smp_sel_t  ssel;
        acc_op_t   aop;
        act_t      act;
    } ucode_t;

    // Control from sequencer to datapath
    typedef struct packed {
        logic      accept;
        logic      run;
        coef_sel_t csel;
        smp_sel_t  ssel;
        acc_op_t   aop;
        logic      rnd1;
        logic      rnd2;
    } lpb_ctrl_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic x_zero;
        logic y1_zero;
    } lpb_stat_t;

    // Product register lags the operand select by one step
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        unique case (s)
            4'd0:    w = '{CS_LP_G,   SS_X,   AOP_NONE, ACT_CHKX};
            4'd1:    w = '{CS_LP_2G,  SS_XN,  AOP_LOAD, ACT_NONE};
            4'd2:    w = '{CS_LP_G,   SS_XO,  AOP_ADD,  ACT_NONE};
            4'd3:    w = '{CS_LP_FBO, SS_S1O, AOP_ADD,  ACT_NONE};
            4'd4:    w = '{CS_LP_FBN, SS_S1N, AOP_ADD,  ACT_NONE};
            4'd5:    w = '{CS_LP_G,   SS_X,   AOP_ADD,  ACT_NONE};
            4'd6:    w = '{CS_LP_G,   SS_X,   AOP_NONE, ACT_RND1};
            4'd7:    w = '{CS_PK_G,   SS_Y1,  AOP_NONE, ACT_NONE};
            4'd8:    w = '{CS_PK_FFO, SS_S1O, AOP_LOAD, ACT_NONE};
            4'd9:    w = '{CS_PK_FFN, SS_S1N, AOP_ADD,  ACT_NONE};
            4'd10:   w = '{CS_PK_FBO, SS_S2O, AOP_ADD,  ACT_NONE};
            4'd11:   w = '{CS_PK_FBN, SS_S2N, AOP_ADD,  ACT_NONE};
            4'd12:   w = '{CS_LP_G,   SS_X,   AOP_ADD,  ACT_NONE};
            4'd13:   w = '{CS_LP_G,   SS_X,   AOP_NONE, ACT_RND2};
            default: w = '{CS_LP_G,   SS_X,   AOP_NONE, ACT_NONE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ design/lpb_ifs.sv @@
// Stream interfaces for the sample input and the filtered output.
`default_nettype none
interface lpb_in_if
    import lpb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = LPB_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           block_end_in;

    modport source (output valid, output sample_in, output block_end_in, input ready);
    modport sink   (input valid, input sample_in, input block_end_in, output ready);
endinterface

interface lpb_out_if
    import lpb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = LPB_SAMPLE_WIDTH
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           block_end_out;

    modport source (output valid, output sample_out, output block_end_out, input ready);
    modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface
`default_nettype wire

@@ design/lpb_coef_bank.sv @@
// Coefficient register file with write port and operand select.
`default_nettype none
module lpb_coef_bank
    import lpb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire cfg_idx_t                cfg_index,
    input  wire coef_t                   cfg_data,
    input  wire coef_sel_t               csel,
    output logic signed [COEF_W:0]       coef_op
);

    coef_t lp_gain_reg, lp_fb_older_reg, lp_fb_newer_reg;
    coef_t pk_ff_older_reg, pk_ff_newer_reg, pk_fb_older_reg, pk_fb_newer_reg;
    coef_t pk_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_gain_reg     <= LP_GAIN_RESET;
            lp_fb_older_reg <= '0;
            lp_fb_newer_reg <= '0;
            pk_ff_older_reg <= '0;
            pk_ff_newer_reg <= '0;
            pk_fb_older_reg <= '0;
            pk_fb_newer_reg <= '0;
            pk_gain_reg     <= PK_GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LP_GAIN:     lp_gain_reg     <= cfg_data;
                REG_LP_FB_OLDER: lp_fb_older_reg <= cfg_data;
                REG_LP_FB_NEWER: lp_fb_newer_reg <= cfg_data;
                REG_PK_FF_OLDER: pk_ff_older_reg <= cfg_data;
                REG_PK_FF_NEWER: pk_ff_newer_reg <= cfg_data;
                REG_PK_FB_OLDER: pk_fb_older_reg <= cfg_data;
                REG_PK_FB_NEWER: pk_fb_newer_reg <= cfg_data;
                REG_PK_GAIN:     pk_gain_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (csel)
            CS_LP_G:   coef_op = {lp_gain_reg[COEF_W-1], lp_gain_reg};
            CS_LP_2G:  coef_op = {lp_gain_reg, 1'b0};
            CS_LP_FBO: coef_op = {lp_fb_older_reg[COEF_W-1], lp_fb_older_reg};
            CS_LP_FBN: coef_op = {lp_fb_newer_reg[COEF_W-1], lp_fb_newer_reg};
            CS_PK_FFO: coef_op = {pk_ff_older_reg[COEF_W-1], pk_ff_older_reg};
            CS_PK_FFN: coef_op = {pk_ff_newer_reg[COEF_W-1], pk_ff_newer_reg};
            CS_PK_FBO: coef_op = {pk_fb_older_reg[COEF_W-1], pk_fb_older_reg};
            CS_PK_FBN: coef_op = {pk_fb_newer_reg[COEF_W-1], pk_fb_newer_reg};
            CS_PK_G:   coef_op = {pk_gain_reg[COEF_W-1], pk_gain_reg};
            default:   coef_op = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ design/lpb_datapath.sv @@
// Shared multiply-accumulate, rounding/saturation and history registers.
`default_nettype none
module lpb_datapath
    import lpb_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = LPB_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = LPB_COEF_FRAC_BITS
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lpb_ctrl_t                      ctrl,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  wire logic signed [COEF_W:0]         coef_op,
    output lpb_stat_t                           stat,
    output logic signed [SAMPLE_WIDTH-1:0]      y_rnd
);

    localparam int PROD_W = COEF_W + 1 + SAMPLE_WIDTH;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SMAX =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMIN =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] x_reg, y1_reg;
    logic signed [SAMPLE_WIDTH-1:0] xn_reg, xo_reg, s1n_reg, s1o_reg, s2n_reg, s2o_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic signed [ACC_W-1:0]        rnd_sum, rnd_shift;

    always_comb
    begin
        unique case (ctrl.ssel)
            SS_X:    smp = x_reg;
            SS_XN:   smp = xn_reg;
            SS_XO:   smp = xo_reg;
            SS_S1N:  smp = s1n_reg;
            SS_S1O:  smp = s1o_reg;
            SS_S2N:  smp = s2n_reg;
            SS_S2O:  smp = s2o_reg;
            SS_Y1:   smp = y1_reg;
            default: smp = x_reg;
        endcase
    end

    // Round half up (floor of sum plus half), then clamp to sample range
    always_comb
    begin
        rnd_sum   = acc_reg + HALF;
        rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
        if (rnd_shift > SMAX)
            y_rnd = SMAX[SAMPLE_WIDTH-1:0];
        else if (rnd_shift < SMIN)
            y_rnd = SMIN[SAMPLE_WIDTH-1:0];
        else
            y_rnd = rnd_shift[SAMPLE_WIDTH-1:0];
    end

    assign stat.x_zero  = (x_reg == '0);
    assign stat.y1_zero = (y_rnd == '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
            x_reg <= sample_in;
        if (ctrl.run)
        begin
            prod_reg <= coef_op * smp;
            unique case (ctrl.aop)
                AOP_LOAD: acc_reg <= ACC_W'(prod_reg);
                AOP_ADD:  acc_reg <= acc_reg + ACC_W'(prod_reg);
                default:  ;
            endcase
            if (ctrl.rnd1)
                y1_reg <= y_rnd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xn_reg  <= '0;
            xo_reg  <= '0;
            s1n_reg <= '0;
            s1o_reg <= '0;
            s2n_reg <= '0;
            s2o_reg <= '0;
        end
        else if (ctrl.run)
        begin
            if (ctrl.rnd1)
            begin
                xo_reg <= xn_reg;
                xn_reg <= x_reg;
            end
            if (ctrl.rnd2)
            begin
                s1o_reg <= s1n_reg;
                s1n_reg <= y1_reg;
                s2o_reg <= s2n_reg;
                s2n_reg <= y_rnd;
            end
        end
    end

endmodule
`default_nettype wire

@@ design/lpb_sequencer.sv @@
// Microcode sequencer: step counter, control ROM and early-exit jumps.
`default_nettype none
module lpb_sequencer
    import lpb_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      out_full,
    input  wire logic      out_ready,
    input  wire lpb_stat_t stat,
    output lpb_ctrl_t      ctrl,
    output logic           emit,
    output logic           emit_zero
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic   state_reg, state_next;
    step_t  step_reg, step_next;
    ucode_t uw;
    logic   stall, done;

    assign uw       = ucode_rom(step_reg);
    assign in_ready = (state_reg == ST_IDLE);

    // A step that emits waits for room in the output register
    assign stall = done && out_full && !out_ready;

    always_comb
    begin
        unique case (uw.act)
            ACT_CHKX: done = stat.x_zero;
            ACT_RND1: done = stat.y1_zero;
            ACT_RND2: done = 1'b1;
            default:  done = 1'b0;
        endcase
    end

    assign ctrl.accept = in_valid && in_ready;
    assign ctrl.run    = (state_reg == ST_RUN) && !stall;
    assign ctrl.csel   = uw.csel;
    assign ctrl.ssel   = uw.ssel;
    assign ctrl.aop    = uw.aop;
    assign ctrl.rnd1   = (uw.act == ACT_RND1);
    assign ctrl.rnd2   = (uw.act == ACT_RND2);

    assign emit      = ctrl.run && done;
    assign emit_zero = (uw.act != ACT_RND2);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        if (ctrl.accept)
        begin
            state_next = ST_RUN;
            step_next  = '0;
        end
        else if (ctrl.run)
        begin
            if (done)
                state_next = ST_IDLE;
            else
                step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule
`default_nettype wire

@@ design/lowpass_peaking_biquad_cascade.sv @@
// Two cascaded biquads (low-pass, then peaking) on one shared MAC.
//
// Channels: in_ch carries sample_in and block_end_in, out_ch carries
// sample_out and block_end_out; a transfer happens when valid and ready are
// both high. Coefficients are written through cfg_we/cfg_index/cfg_data
// only while no sample is in flight, a rule the block leaves to the user.
// One sample is processed at a time; ready is low from the transfer until
// the result is loaded into the output register.
// out_ch.valid follows the last step for a normal sample, the first
// rounding step when it gives zero, and the input check for a zero input.
// The sequencer steps the single 25x(SAMPLE_WIDTH) multiplier through ten
// products, two pipeline fill steps and two rounding steps (14 steps); a
// new sample is accepted only once the current one has finished.
// The output register holds a finished result while the sink stalls; the
// next sample is still taken and runs until its last step, which waits.
// Reset clears the histories, restores default coefficients and empties the
// output register.
`default_nettype none
module lowpass_peaking_biquad_cascade
    import lpb_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = LPB_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = LPB_COEF_FRAC_BITS
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    lpb_in_if.sink          in_ch,
    lpb_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire cfg_idx_t   cfg_index,
    input  wire coef_t      cfg_data
);

    lpb_ctrl_t                      ctrl;
    lpb_stat_t                      stat;
    logic signed [COEF_W:0]         coef_op;
    logic signed [SAMPLE_WIDTH-1:0] y_rnd;
    logic                           emit, emit_zero;
    logic                           mark_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                           out_end_reg;

    lpb_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_full  (out_valid_reg),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctrl      (ctrl),
        .emit      (emit),
        .emit_zero (emit_zero)
    );

    lpb_coef_bank u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .csel      (ctrl.csel),
        .coef_op   (coef_op)
    );

    lpb_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample_in (in_ch.sample_in),
        .coef_op   (coef_op),
        .stat      (stat),
        .y_rnd     (y_rnd)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
            mark_reg <= in_ch.block_end_in;
        if (emit)
        begin
            out_sample_reg <= emit_zero ? '0 : y_rnd;
            out_end_reg    <= mark_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.sample_out    = out_sample_reg;
    assign out_ch.block_end_out = out_end_reg;

endmodule
`default_nettype wire

@@ design/lpb_checker.sv @@
// Port-level assertions for the biquad cascade, bound to the top level.
`default_nettype none
module lpb_checker
    import lpb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = LPB_SAMPLE_WIDTH
)
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [SAMPLE_WIDTH-1:0] sample_out,
    input wire logic                    block_end_out
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
            && $stable(block_end_out))
        else $error("output changed while stalled");

    // One sample in flight: ready drops after every input transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while one is in flight");

    // A new result only comes from a sample that was in flight
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared with no sample in flight");

    // Ready comes back no later than the result appears
    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("block still busy after delivering its result");

endmodule

bind lowpass_peaking_biquad_cascade lpb_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lpb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .sample_out    (out_ch.sample_out),
    .block_end_out (out_ch.block_end_out)
);
`default_nettype wire
